/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the cursor tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disabled
`define MCT_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disabled
`define MCT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mct_pkg.sv */
// Types, widths and codes shared across the cursor tracker RTL
`timescale 1ns / 1ps

package mct_pkg;

    // Field widths of the event, result and register items
    localparam int OP_W    = 2;
    localparam int DELTA_W = 13;
    localparam int BTN_W   = 6;
    localparam int SPEED_W = 12;
    localparam int ACCEL_W = 16;
    localparam int SIZE_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Event kinds
    localparam logic [OP_W-1:0] OP_MOVE    = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_RESET  = 12'd256;
    localparam logic [ACCEL_W-1:0] ACCEL_RESET  = 16'd0;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;

    // Buttons one and two swap into each other: new = SWAP_SUM - old
    localparam logic [BTN_W-1:0] SWAP_SUM = 6'd3;

    // Datapath widths
    localparam int MAG_W   = 24;   // scaled delta magnitude
    localparam int MUL_W   = 25;   // shared multiplier operand
    localparam int PROD_W  = 50;   // shared multiplier product
    localparam int SQ_W    = 48;   // one squared magnitude
    localparam int RAD_W   = 50;   // square root radicand
    localparam int ROOT_W  = 25;   // square root result
    localparam int REM_W   = 28;   // square root remainder
    localparam int ACC_W   = 34;   // acceleration factor, Q.12
    localparam int HALF_W  = 17;   // acceleration half fed to the multiplier
    localparam int PART_W  = 41;   // partial product of magnitude and half factor
    localparam int FULL_W  = 58;   // full product of magnitude and factor
    localparam int MV_W    = 38;   // integer move magnitude
    localparam int SUM_W   = 40;   // signed new position before clamp
    localparam int ACC_SHIFT  = 8;
    localparam int MV_SHIFT   = 20;
    localparam logic [ACC_W-1:0] ACC_ONE = 34'd4096;

    // Square root iterations, one result bit each
    localparam int ROOT_STEPS = 25;
    localparam int CNT_W      = 5;

    // Datapath step codes
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_NONE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_X  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_Y  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SQ_X   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SQ_Y   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SUM    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ROOT   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MUL_A  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ACC    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_X_LO   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_X_HI   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_Y_LO   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_Y_HI   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_MV_Y   = 4'd13;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd14;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_move;
    } status_t;

endpackage

/* rtl/mct_event_if.sv */
// Pointer event channel
`timescale 1ns / 1ps

interface mct_event_if;
    logic                                 valid;
    logic                                 ready;
    logic [mct_pkg::OP_W-1:0]             op;
    logic signed [mct_pkg::DELTA_W-1:0]   delta_x;
    logic signed [mct_pkg::DELTA_W-1:0]   delta_y;
    logic [mct_pkg::BTN_W-1:0]            button_number;

    modport source (output valid, op, delta_x, delta_y, button_number, input ready);
    modport sink   (input valid, op, delta_x, delta_y, button_number, output ready);
endinterface

/* rtl/mct_result_if.sv */
// Cursor result channel
`timescale 1ns / 1ps

interface mct_result_if #(
    parameter int COORD_BITS  = 12,
    parameter int NUM_BUTTONS = 32
);
    logic                      valid;
    logic                      ready;
    logic [COORD_BITS-1:0]     cursor_x;
    logic [COORD_BITS-1:0]     cursor_y;
    logic [NUM_BUTTONS-1:0]    buttons_held;
    logic [mct_pkg::BTN_W-1:0] mapped_button;

    modport source (output valid, cursor_x, cursor_y, buttons_held, mapped_button,
                    input ready);
    modport sink   (input valid, cursor_x, cursor_y, buttons_held, mapped_button,
                    output ready);
endinterface

/* rtl/mct_cfg_if.sv */
// Register write channel
`timescale 1ns / 1ps

interface mct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mct_pkg::CFG_IDX_W-1:0]  index;
    logic [mct_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mct_ctrl.sv */
// Sequencer that steps the cursor datapath through one event
`timescale 1ns / 1ps

module mct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    output logic             evt_ready,
    input  logic             out_free,
    input  mct_pkg::status_t status,
    output mct_pkg::cmd_t    cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_MUL_X  = 4'd1;
    localparam logic [ST_W-1:0] S_MUL_Y  = 4'd2;
    localparam logic [ST_W-1:0] S_SQ_X   = 4'd3;
    localparam logic [ST_W-1:0] S_SQ_Y   = 4'd4;
    localparam logic [ST_W-1:0] S_SUM    = 4'd5;
    localparam logic [ST_W-1:0] S_ROOT   = 4'd6;
    localparam logic [ST_W-1:0] S_MUL_A  = 4'd7;
    localparam logic [ST_W-1:0] S_ACC    = 4'd8;
    localparam logic [ST_W-1:0] S_X_LO   = 4'd9;
    localparam logic [ST_W-1:0] S_X_HI   = 4'd10;
    localparam logic [ST_W-1:0] S_Y_LO   = 4'd11;
    localparam logic [ST_W-1:0] S_Y_HI   = 4'd12;
    localparam logic [ST_W-1:0] S_MV_Y   = 4'd13;
    localparam logic [ST_W-1:0] S_COMMIT = 4'd14;

    logic [ST_W-1:0]              state_reg;
    logic [ST_W-1:0]              state_next;
    logic [mct_pkg::CNT_W-1:0]    cnt_reg;
    logic [mct_pkg::CNT_W-1:0]    cnt_next;

    // Take an item only when nothing is in flight
    assign evt_ready = (state_reg == S_IDLE);

    // Next state and step command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.load   = 1'b0;
        cmd.step   = mct_pkg::STEP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                cmd.step   = mct_pkg::STEP_MUL_X;
                state_next = status.is_move ? S_MUL_Y : S_COMMIT;
            end
            S_MUL_Y:
            begin
                cmd.step   = mct_pkg::STEP_MUL_Y;
                state_next = S_SQ_X;
            end
            S_SQ_X:
            begin
                cmd.step   = mct_pkg::STEP_SQ_X;
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                cmd.step   = mct_pkg::STEP_SQ_Y;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.step   = mct_pkg::STEP_SUM;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.step = mct_pkg::STEP_ROOT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mct_pkg::CNT_W'(mct_pkg::ROOT_STEPS - 1))
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.step   = mct_pkg::STEP_MUL_A;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.step   = mct_pkg::STEP_ACC;
                state_next = S_X_LO;
            end
            S_X_LO:
            begin
                cmd.step   = mct_pkg::STEP_X_LO;
                state_next = S_X_HI;
            end
            S_X_HI:
            begin
                cmd.step   = mct_pkg::STEP_X_HI;
                state_next = S_Y_LO;
            end
            S_Y_LO:
            begin
                cmd.step   = mct_pkg::STEP_Y_LO;
                state_next = S_Y_HI;
            end
            S_Y_HI:
            begin
                cmd.step   = mct_pkg::STEP_Y_HI;
                state_next = S_MV_Y;
            end
            S_MV_Y:
            begin
                cmd.step   = mct_pkg::STEP_MV_Y;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Hold until the result slot can take the item
                if (out_free)
                begin
                    cmd.step   = mct_pkg::STEP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/mct_datapath.sv */
// Cursor datapath: shared multiplier, bit-serial square root, clamp and button mask
`timescale 1ns / 1ps

module mct_datapath #(
    parameter int COORD_BITS  = 12,
    parameter int NUM_BUTTONS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mct_pkg::cmd_t                      cmd,
    output mct_pkg::status_t                   status,
    input  logic [mct_pkg::OP_W-1:0]           in_op,
    input  logic signed [mct_pkg::DELTA_W-1:0] in_dx,
    input  logic signed [mct_pkg::DELTA_W-1:0] in_dy,
    input  logic [mct_pkg::BTN_W-1:0]          in_btn,
    input  logic [mct_pkg::SPEED_W-1:0]        speed_gain,
    input  logic [mct_pkg::ACCEL_W-1:0]        accel_gain,
    input  logic                               swap_buttons,
    input  logic [mct_pkg::SIZE_W-1:0]         screen_width,
    input  logic [mct_pkg::SIZE_W-1:0]         screen_height,
    output logic [COORD_BITS-1:0]              pos_x,
    output logic [COORD_BITS-1:0]              pos_y,
    output logic [NUM_BUTTONS-1:0]             held,
    output logic [mct_pkg::BTN_W-1:0]          mapped
);

    localparam int LIM_W = (COORD_BITS + 1 > mct_pkg::SIZE_W) ? COORD_BITS + 1
                                                              : mct_pkg::SIZE_W;

    // Captured event
    logic [mct_pkg::OP_W-1:0]           op_reg;
    logic signed [mct_pkg::DELTA_W-1:0] dx_reg;
    logic signed [mct_pkg::DELTA_W-1:0] dy_reg;
    logic [mct_pkg::BTN_W-1:0]          btn_reg;

    // Working registers
    logic [mct_pkg::MAG_W-1:0]  ax_reg;
    logic [mct_pkg::MAG_W-1:0]  ay_reg;
    logic [mct_pkg::PROD_W-1:0] prod_reg;
    logic [mct_pkg::SQ_W-1:0]   sq_reg;
    logic [mct_pkg::RAD_W-1:0]  rad_reg;
    logic [mct_pkg::REM_W-1:0]  rem_reg;
    logic [mct_pkg::ROOT_W-1:0] root_reg;
    logic [mct_pkg::ACC_W-1:0]  acc_reg;
    logic [mct_pkg::PART_W-1:0] part_reg;
    logic [mct_pkg::MV_W-1:0]   mvx_reg;
    logic [mct_pkg::MV_W-1:0]   mvy_reg;

    // State and result
    logic [COORD_BITS-1:0]     pos_x_reg;
    logic [COORD_BITS-1:0]     pos_y_reg;
    logic [NUM_BUTTONS-1:0]    held_reg;
    logic [mct_pkg::BTN_W-1:0] mapped_reg;

    logic [mct_pkg::DELTA_W-1:0] abs_dx;
    logic [mct_pkg::DELTA_W-1:0] abs_dy;
    logic [mct_pkg::MUL_W-1:0]   mul_a;
    logic [mct_pkg::MUL_W-1:0]   mul_b;
    logic [mct_pkg::PROD_W-1:0]  mul_p;
    logic [mct_pkg::REM_W-1:0]   rem_sh;
    logic [mct_pkg::REM_W-1:0]   trial;
    logic [mct_pkg::FULL_W-1:0]  full_sum;
    logic [mct_pkg::MV_W-1:0]    mv_now;

    logic                          is_move;
    logic signed [mct_pkg::SUM_W-1:0] step_x;
    logic signed [mct_pkg::SUM_W-1:0] step_y;
    logic signed [mct_pkg::SUM_W-1:0] nx;
    logic signed [mct_pkg::SUM_W-1:0] ny;
    logic                          btn_ok;
    logic [mct_pkg::BTN_W-1:0]     btn_map;
    logic [NUM_BUTTONS-1:0]        btn_bit;
    logic [NUM_BUTTONS-1:0]        held_next;
    logic [mct_pkg::BTN_W-1:0]     mapped_next;

    // Clamp a signed position to [0, limit-1]; a size of zero acts as one
    function automatic logic [COORD_BITS-1:0] clamp_pos(
        input logic signed [mct_pkg::SUM_W-1:0] p,
        input logic [mct_pkg::SIZE_W-1:0]       size
    );
        logic [LIM_W-1:0]         lim;
        logic [LIM_W-1:0]         lim_max;
        logic [mct_pkg::SUM_W-1:0] p_u;
        lim_max = LIM_W'(1) << COORD_BITS;
        lim     = (size == '0) ? LIM_W'(1) : LIM_W'(size);
        p_u     = p;
        if (lim > lim_max)
        begin
            lim = lim_max;
        end
        if (p[mct_pkg::SUM_W-1])
        begin
            clamp_pos = '0;
        end
        else if (p_u >= mct_pkg::SUM_W'(lim))
        begin
            clamp_pos = COORD_BITS'(lim - 1'b1);
        end
        else
        begin
            clamp_pos = COORD_BITS'(p_u);
        end
    endfunction

    assign is_move        = (op_reg == mct_pkg::OP_MOVE);
    assign status.is_move = is_move;

    assign abs_dx = dx_reg[mct_pkg::DELTA_W-1] ? mct_pkg::DELTA_W'(-dx_reg)
                                               : mct_pkg::DELTA_W'(dx_reg);
    assign abs_dy = dy_reg[mct_pkg::DELTA_W-1] ? mct_pkg::DELTA_W'(-dy_reg)
                                               : mct_pkg::DELTA_W'(dy_reg);

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            mct_pkg::STEP_MUL_X:
            begin
                mul_a = mct_pkg::MUL_W'(abs_dx);
                mul_b = mct_pkg::MUL_W'(speed_gain);
            end
            mct_pkg::STEP_MUL_Y:
            begin
                mul_a = mct_pkg::MUL_W'(abs_dy);
                mul_b = mct_pkg::MUL_W'(speed_gain);
            end
            mct_pkg::STEP_SQ_X:
            begin
                mul_a = mct_pkg::MUL_W'(ax_reg);
                mul_b = mct_pkg::MUL_W'(ax_reg);
            end
            mct_pkg::STEP_SQ_Y:
            begin
                mul_a = mct_pkg::MUL_W'(ay_reg);
                mul_b = mct_pkg::MUL_W'(ay_reg);
            end
            mct_pkg::STEP_MUL_A:
            begin
                mul_a = root_reg;
                mul_b = mct_pkg::MUL_W'(accel_gain);
            end
            mct_pkg::STEP_X_LO:
            begin
                mul_a = mct_pkg::MUL_W'(ax_reg);
                mul_b = mct_pkg::MUL_W'(acc_reg[mct_pkg::HALF_W-1:0]);
            end
            mct_pkg::STEP_X_HI:
            begin
                mul_a = mct_pkg::MUL_W'(ax_reg);
                mul_b = mct_pkg::MUL_W'(acc_reg[mct_pkg::ACC_W-1:mct_pkg::HALF_W]);
            end
            mct_pkg::STEP_Y_LO:
            begin
                mul_a = mct_pkg::MUL_W'(ay_reg);
                mul_b = mct_pkg::MUL_W'(acc_reg[mct_pkg::HALF_W-1:0]);
            end
            mct_pkg::STEP_Y_HI:
            begin
                mul_a = mct_pkg::MUL_W'(ay_reg);
                mul_b = mct_pkg::MUL_W'(acc_reg[mct_pkg::ACC_W-1:mct_pkg::HALF_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One result bit of the square root
    assign rem_sh = {rem_reg[mct_pkg::REM_W-3:0], rad_reg[mct_pkg::RAD_W-1 -: 2]};
    assign trial  = mct_pkg::REM_W'({root_reg, 2'b01});

    // Join the two partial products and drop the fraction
    assign full_sum = mct_pkg::FULL_W'(part_reg)
                    + (mct_pkg::FULL_W'(prod_reg[mct_pkg::PART_W-1:0]) << mct_pkg::HALF_W);
    assign mv_now   = mct_pkg::MV_W'(full_sum >> mct_pkg::MV_SHIFT);

    // New positions: move toward zero-truncated steps, nothing for buttons
    assign step_x = dx_reg[mct_pkg::DELTA_W-1] ? -$signed(mct_pkg::SUM_W'(mvx_reg))
                                               : $signed(mct_pkg::SUM_W'(mvx_reg));
    assign step_y = dy_reg[mct_pkg::DELTA_W-1] ? -$signed(mct_pkg::SUM_W'(mvy_reg))
                                               : $signed(mct_pkg::SUM_W'(mvy_reg));
    assign nx = $signed(mct_pkg::SUM_W'(pos_x_reg)) + (is_move ? step_x : '0);
    assign ny = $signed(mct_pkg::SUM_W'(pos_y_reg)) + (is_move ? step_y : '0);

    // Button map and held mask update
    always_comb
    begin
        btn_ok  = (btn_reg != '0) && (btn_reg <= mct_pkg::BTN_W'(NUM_BUTTONS));
        btn_map = btn_reg;
        if (swap_buttons && (btn_reg == mct_pkg::BTN_W'(1) || btn_reg == mct_pkg::BTN_W'(2)))
        begin
            btn_map = mct_pkg::SWAP_SUM - btn_reg;
        end
        btn_bit     = NUM_BUTTONS'(1) << (btn_map - 1'b1);
        held_next   = held_reg;
        mapped_next = '0;
        unique case (op_reg)
            mct_pkg::OP_PRESS:
            begin
                if (btn_ok)
                begin
                    held_next   = held_reg | btn_bit;
                    mapped_next = btn_map;
                end
            end
            mct_pkg::OP_RELEASE:
            begin
                if (btn_ok)
                begin
                    held_next   = held_reg & ~btn_bit;
                    mapped_next = btn_map;
                end
            end
            default:
            begin
                held_next   = held_reg;
                mapped_next = '0;
            end
        endcase
    end

    // Capture the event and run the arithmetic steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            dx_reg  <= in_dx;
            dy_reg  <= in_dy;
            btn_reg <= in_btn;
        end
        prod_reg <= mul_p;
        unique case (cmd.step)
            mct_pkg::STEP_MUL_Y:
            begin
                ax_reg <= prod_reg[mct_pkg::MAG_W-1:0];
            end
            mct_pkg::STEP_SQ_X:
            begin
                ay_reg <= prod_reg[mct_pkg::MAG_W-1:0];
            end
            mct_pkg::STEP_SQ_Y:
            begin
                sq_reg <= prod_reg[mct_pkg::SQ_W-1:0];
            end
            mct_pkg::STEP_SUM:
            begin
                rad_reg  <= mct_pkg::RAD_W'(sq_reg) + mct_pkg::RAD_W'(prod_reg[mct_pkg::SQ_W-1:0]);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            mct_pkg::STEP_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[mct_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[mct_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            mct_pkg::STEP_ACC:
            begin
                acc_reg <= mct_pkg::ACC_ONE
                         + mct_pkg::ACC_W'(prod_reg[mct_pkg::PROD_W-1:mct_pkg::ACC_SHIFT]);
            end
            mct_pkg::STEP_X_HI:
            begin
                part_reg <= prod_reg[mct_pkg::PART_W-1:0];
            end
            mct_pkg::STEP_Y_LO:
            begin
                mvx_reg <= mv_now;
            end
            mct_pkg::STEP_Y_HI:
            begin
                part_reg <= prod_reg[mct_pkg::PART_W-1:0];
            end
            mct_pkg::STEP_MV_Y:
            begin
                mvy_reg <= mv_now;
            end
            default:
            begin
            end
        endcase
    end

    // Commit the event: clamp, update the mask, present the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            held_reg   <= '0;
            mapped_reg <= '0;
        end
        else if (cmd.step == mct_pkg::STEP_COMMIT)
        begin
            pos_x_reg  <= clamp_pos(nx, screen_width);
            pos_y_reg  <= clamp_pos(ny, screen_height);
            held_reg   <= held_next;
            mapped_reg <= mapped_next;
        end
    end

    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign held   = held_reg;
    assign mapped = mapped_reg;

endmodule

/* rtl/mouse_cursor_tracker.sv */
// Pointer event tracker: accelerated relative moves, button mask, screen clamp
// A move runs the shared 25x25 multiplier steps and the 25-step bit-serial square root;
//   a press or release goes from its first multiply step straight to commit.
// One event is in flight at a time: a new one is taken only after the last is committed.
// A finished item waits in the output register while the next one is taken in.
// Reset (rst_n low, asynchronous): cursor at 0,0, no buttons held, registers at defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mouse_cursor_tracker #(
    parameter int COORD_BITS  = 12,
    parameter int NUM_BUTTONS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    mct_event_if.sink     evt,
    mct_result_if.source  res,
    mct_cfg_if.sink       cfg
);

    logic [mct_pkg::SPEED_W-1:0] speed_gain_reg;
    logic [mct_pkg::ACCEL_W-1:0] accel_gain_reg;
    logic                        swap_buttons_reg;
    logic [mct_pkg::SIZE_W-1:0]  screen_width_reg;
    logic [mct_pkg::SIZE_W-1:0]  screen_height_reg;

    logic                 out_valid_reg;
    logic                 out_free;
    logic                 commit;
    mct_pkg::cmd_t        cmd;
    mct_pkg::status_t     status;

    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic [NUM_BUTTONS-1:0]    held;
    logic [mct_pkg::BTN_W-1:0] mapped;
    logic                      x_in_range;
    logic                      y_in_range;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg    <= mct_pkg::SPEED_RESET;
            accel_gain_reg    <= mct_pkg::ACCEL_RESET;
            swap_buttons_reg  <= 1'b0;
            screen_width_reg  <= mct_pkg::WIDTH_RESET;
            screen_height_reg <= mct_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mct_pkg::REG_SPEED:  speed_gain_reg    <= cfg.data[mct_pkg::SPEED_W-1:0];
                mct_pkg::REG_ACCEL:  accel_gain_reg    <= cfg.data[mct_pkg::ACCEL_W-1:0];
                mct_pkg::REG_SWAP:   swap_buttons_reg  <= cfg.data[0];
                mct_pkg::REG_WIDTH:  screen_width_reg  <= cfg.data[mct_pkg::SIZE_W-1:0];
                mct_pkg::REG_HEIGHT: screen_height_reg <= cfg.data[mct_pkg::SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .out_free  (out_free),
        .status    (status),
        .cmd       (cmd)
    );

    mct_datapath #(
        .COORD_BITS  (COORD_BITS),
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_op         (evt.op),
        .in_dx         (evt.delta_x),
        .in_dy         (evt.delta_y),
        .in_btn        (evt.button_number),
        .speed_gain    (speed_gain_reg),
        .accel_gain    (accel_gain_reg),
        .swap_buttons  (swap_buttons_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .held          (held),
        .mapped        (mapped)
    );

    // The datapath result registers hold the item; track whether it is pending
    assign commit   = (cmd.step == mct_pkg::STEP_COMMIT);
    assign out_free = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.cursor_x      = pos_x;
    assign res.cursor_y      = pos_y;
    assign res.buttons_held  = held;
    assign res.mapped_button = mapped;

    // Positions stay on screen; a size of zero allows only coordinate zero
    assign x_in_range = (mct_pkg::SUM_W'(pos_x) < mct_pkg::SUM_W'(screen_width_reg))
                     || (pos_x == '0);
    assign y_in_range = (mct_pkg::SUM_W'(pos_y) < mct_pkg::SUM_W'(screen_height_reg))
                     || (pos_y == '0);

    `MCT_ASSERT_NOW(a_no_overwrite, clk, rst_n, commit, !out_valid_reg || res.ready, "result overwritten before it was taken")
    `MCT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, evt.valid && evt.ready, !evt.ready, "second item taken while one is in flight")
    `MCT_ASSERT_NEXT(a_on_screen, clk, rst_n, commit, x_in_range && y_in_range, "cursor left the screen after commit")

endmodule
